@@ hw/rtl/i2ctb_pkg.sv @@
package i2ctb_pkg;

  // Buffer geometry
  localparam int BUF_SIZE = 32;
  localparam int POS_W    = $clog2(BUF_SIZE + 1);
  localparam int IDX_W    = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;
  localparam int COUNT_W  = 6;
  localparam int ACTION_W = 3;
  localparam int BYTE_W   = 8;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Event codes on the input channel
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADDR  = 3'd0,
    ACT_RECV  = 3'd1,
    ACT_TX    = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_NACK  = 3'd4,
    ACT_POP   = 3'd5
  } action_t;

  // Datapath operations selected by the control word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADDR,
    OP_RECV,
    OP_TX,
    OP_STOP,
    OP_POP,
    OP_NACK,
    OP_EMIT
  } dp_op_t;

  // Sequencing conditions
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_DISPATCH,
    COND_WAIT_OUT
  } cond_t;

  // Microprogram addresses
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_DECODE = 4'd1;
  localparam step_t STEP_ADDR   = 4'd2;
  localparam step_t STEP_RECV   = 4'd3;
  localparam step_t STEP_TX     = 4'd4;
  localparam step_t STEP_STOP   = 4'd5;
  localparam step_t STEP_POP    = 4'd6;
  localparam step_t STEP_NACK   = 4'd7;
  localparam step_t STEP_EMIT   = 4'd8;

  typedef struct packed {
    logic   in_ready;
    cond_t  cond;
    step_t  target;
    dp_op_t op;
  } ctl_word_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    action_t action;
    logic    slot_free;
  } dp_status_t;

  // Control store
  function automatic ctl_word_t ucode(input step_t s);
    ctl_word_t cw;
    cw = '{in_ready: 1'b0, cond: COND_NEXT, target: STEP_IDLE, op: OP_NONE};
    unique case (s)
      STEP_IDLE:   cw = '{1'b1, COND_WAIT_IN,  STEP_DECODE, OP_NONE};
      STEP_DECODE: cw = '{1'b0, COND_DISPATCH, STEP_NACK,   OP_NONE};
      STEP_ADDR:   cw = '{1'b0, COND_NEXT,     STEP_EMIT,   OP_ADDR};
      STEP_RECV:   cw = '{1'b0, COND_NEXT,     STEP_EMIT,   OP_RECV};
      STEP_TX:     cw = '{1'b0, COND_NEXT,     STEP_EMIT,   OP_TX};
      STEP_STOP:   cw = '{1'b0, COND_NEXT,     STEP_EMIT,   OP_STOP};
      STEP_POP:    cw = '{1'b0, COND_NEXT,     STEP_EMIT,   OP_POP};
      STEP_NACK:   cw = '{1'b0, COND_NEXT,     STEP_EMIT,   OP_NACK};
      STEP_EMIT:   cw = '{1'b0, COND_WAIT_OUT, STEP_IDLE,   OP_EMIT};
      default:     cw = '{1'b0, COND_NEXT,     STEP_IDLE,   OP_NONE};
    endcase
    return cw;
  endfunction

  // Dispatch table: event code to handler step
  function automatic step_t dispatch(input action_t a);
    step_t s;
    unique case (a)
      ACT_ADDR: s = STEP_ADDR;
      ACT_RECV: s = STEP_RECV;
      ACT_TX:   s = STEP_TX;
      ACT_STOP: s = STEP_STOP;
      ACT_POP:  s = STEP_POP;
      default:  s = STEP_NACK;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/i2ctb_if.sv @@
interface i2ctb_in_if;
  logic                              valid;
  logic                              ready;
  logic [i2ctb_pkg::ACTION_W-1:0]    action;
  logic [i2ctb_pkg::BYTE_W-1:0]      data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

interface i2ctb_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ack_continue;
  logic [i2ctb_pkg::BYTE_W-1:0]      tx_byte;
  logic [i2ctb_pkg::BYTE_W-1:0]      popped_byte;
  logic [i2ctb_pkg::COUNT_W-1:0]     available_count;

  modport source (output valid, output ack_continue, output tx_byte,
                  output popped_byte, output available_count, input ready);
  modport sink   (input valid, input ack_continue, input tx_byte,
                  input popped_byte, input available_count, output ready);
endinterface

@@ hw/rtl/i2c_target_byte_buffer_unit.sv @@
// Channel  Direction  Payload
// in_ch    sink       action[2:0], data_in[7:0]
// out_ch   source     ack_continue, tx_byte[7:0], popped_byte[7:0],
//                     available_count[5:0]
//
// Each transaction passes through the microprogram steps: accept,
// dispatch on the event code, one datapath step, then result load.
// The result sits in an output register, so the next transaction is
// accepted while an earlier result waits for out_ch.ready.
// A stalled output holds the sequencer in its load step.
// Synchronous active-low reset clears the buffer, index and out valid.
module i2c_target_byte_buffer_unit (
  input  logic         clk,
  input  logic         rst_n,
  i2ctb_in_if.sink     in_ch,
  i2ctb_out_if.source  out_ch
);

  i2ctb_pkg::ctl_word_t  ctl;
  i2ctb_pkg::dp_status_t status;

  i2ctb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .ctl      (ctl)
  );

  i2ctb_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ hw/rtl/i2ctb_seq.sv @@
module i2ctb_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  i2ctb_pkg::dp_status_t  status,
  output i2ctb_pkg::ctl_word_t   ctl
);

  i2ctb_pkg::step_t pc_r;
  i2ctb_pkg::step_t pc_nxt;

  // Control word for the current step
  assign ctl = i2ctb_pkg::ucode(pc_r);

  // Next step selection
  always_comb begin
    pc_nxt = pc_r;
    unique case (ctl.cond)
      i2ctb_pkg::COND_NEXT:     pc_nxt = ctl.target;
      i2ctb_pkg::COND_WAIT_IN:  if (in_valid) pc_nxt = ctl.target;
      i2ctb_pkg::COND_DISPATCH: pc_nxt = i2ctb_pkg::dispatch(status.action);
      i2ctb_pkg::COND_WAIT_OUT: if (status.slot_free) pc_nxt = ctl.target;
      default:                  pc_nxt = i2ctb_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= i2ctb_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hw/rtl/i2ctb_datapath.sv @@
module i2ctb_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  i2ctb_pkg::ctl_word_t   ctl,
  output i2ctb_pkg::dp_status_t  status,
  i2ctb_in_if.sink               in_ch,
  i2ctb_out_if.source            out_ch
);

  localparam int N = i2ctb_pkg::BUF_SIZE;

  i2ctb_pkg::byte_t   store_r [N];
  i2ctb_pkg::pos_t    pos_r;
  logic               idle_r;
  i2ctb_pkg::action_t action_r;
  i2ctb_pkg::byte_t   data_r;

  // Pending result of the current transaction
  logic               res_ack_r;
  i2ctb_pkg::byte_t   res_tx_r;
  i2ctb_pkg::byte_t   res_pop_r;

  // Output register
  logic                             out_valid_r;
  logic                             out_ack_r;
  i2ctb_pkg::byte_t                 out_tx_r;
  i2ctb_pkg::byte_t                 out_pop_r;
  logic [i2ctb_pkg::COUNT_W-1:0]    out_cnt_r;

  i2ctb_pkg::pos_t    pos_eff;
  logic               has_room;
  i2ctb_pkg::byte_t   rd_byte;
  logic               in_acc;
  logic               slot_free;
  i2ctb_pkg::pos_t    cnt_now;

  assign in_acc    = in_ch.valid && ctl.in_ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // An idle index counts as zero when first used
  assign pos_eff  = idle_r ? '0 : pos_r;
  assign has_room = pos_eff < i2ctb_pkg::pos_t'(N);
  assign rd_byte  = store_r[pos_eff[i2ctb_pkg::IDX_W-1:0]];
  assign cnt_now  = idle_r ? '0 : pos_r;

  assign status.action    = action_r;
  assign status.slot_free = slot_free;

  assign in_ch.ready            = ctl.in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.ack_continue    = out_ack_r;
  assign out_ch.tx_byte         = out_tx_r;
  assign out_ch.popped_byte     = out_pop_r;
  assign out_ch.available_count = out_cnt_r;

  // Input latch and result registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= i2ctb_pkg::action_t'(in_ch.action);
      data_r   <= in_ch.data_in;
    end
    case (ctl.op) inside
      i2ctb_pkg::OP_ADDR, i2ctb_pkg::OP_RECV, i2ctb_pkg::OP_STOP: begin
        res_ack_r <= 1'b1;
        res_tx_r  <= '0;
        res_pop_r <= '0;
      end
      i2ctb_pkg::OP_TX: begin
        res_ack_r <= 1'b1;
        res_tx_r  <= has_room ? rd_byte : '0;
        res_pop_r <= '0;
      end
      i2ctb_pkg::OP_POP: begin
        res_ack_r <= 1'b0;
        res_tx_r  <= '0;
        res_pop_r <= (!idle_r && pos_r != '0) ? store_r[0] : '0;
      end
      i2ctb_pkg::OP_NACK: begin
        res_ack_r <= 1'b0;
        res_tx_r  <= '0;
        res_pop_r <= '0;
      end
      default: ;
    endcase
    if (ctl.op == i2ctb_pkg::OP_EMIT && slot_free) begin
      out_ack_r <= res_ack_r;
      out_tx_r  <= res_tx_r;
      out_pop_r <= res_pop_r;
      out_cnt_r <= i2ctb_pkg::COUNT_W'(cnt_now);
    end
  end

  // Buffer cells, index and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        store_r[i] <= '0;
      end
      pos_r       <= '0;
      idle_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.op)
        i2ctb_pkg::OP_ADDR: begin
          pos_r  <= '0;
          idle_r <= 1'b1;
        end
        i2ctb_pkg::OP_RECV: begin
          idle_r <= 1'b0;
          if (has_room) begin
            store_r[pos_eff[i2ctb_pkg::IDX_W-1:0]] <= data_r;
            pos_r <= pos_eff + 1'b1;
          end else begin
            pos_r <= pos_eff;
          end
        end
        i2ctb_pkg::OP_TX: begin
          idle_r <= 1'b0;
          pos_r  <= has_room ? pos_eff + 1'b1 : pos_eff;
        end
        i2ctb_pkg::OP_POP: begin
          if (!idle_r && pos_r != '0) begin
            // Occupied cells shift down; the last occupied cell keeps its value
            for (int i = 0; i < N - 1; i++) begin
              if (i2ctb_pkg::pos_t'(i + 1) < pos_r) begin
                store_r[i] <= store_r[i+1];
              end
            end
            pos_r <= pos_r - 1'b1;
          end
        end
        default: ;
      endcase
      if (ctl.op == i2ctb_pkg::OP_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
